// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mlfqs_pkg.sv =====
// Types, constants and helper functions of the scheduler arithmetic unit
`default_nettype none

package mlfqs_pkg;

   localparam int FRAC_BITS_DEFAULT = 14;

   localparam logic [7:0] MAX_PRIORITY_RESET = 8'd63;
   localparam logic [7:0] MIN_PRIORITY_RESET = 8'd0;

   localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      OP_LOAD     = 2'd0,
      OP_RECENT   = 2'd1,
      OP_PRIORITY = 2'd2,
      OP_REPORT   = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      CSR_MAX_PRIORITY = 1'b0,
      CSR_MIN_PRIORITY = 1'b1
   } csr_index_type;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_PREP  = 10'b00_0000_0010,
      ST_DLOAD = 10'b00_0000_0100,
      ST_DIV   = 10'b00_0000_1000,
      ST_CSET  = 10'b00_0001_0000,
      ST_MLOAD = 10'b00_0010_0000,
      ST_MUL   = 10'b00_0100_0000,
      ST_MSAT  = 10'b00_1000_0000,
      ST_PRI   = 10'b01_0000_0000,
      ST_FIN   = 10'b10_0000_0000
   } state_type;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [31:0] r;
      r = v[31] ? 32'(-v) : 32'(v);
      return r;
   endfunction

   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? S32_MIN : S32_MAX;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mlfqs_load_priority_unit.sv =====
// Top level of the scheduler load, recent cpu and priority arithmetic unit
//
// A request word carries an operation code and its operands; every request
// gives exactly one response word. Operation 0 folds the ready count into the
// kept load average, 1 returns a new recent cpu, 2 a clamped priority and 3
// the load average times 100. Both channels use valid/stall; the configuration
// port writes the priority bounds with no wait and must be used while idle.
// Load update and load report run through the 32-step bit-serial multiplier;
// recent cpu first runs a restoring divider that makes 32 + FRAC_BITS quotient
// bits, one step per bit, then the serial multiplier; priority uses neither.
// One request is in work at a time; req_stall is high until it completes.
// The response sits in an output register: a new request is taken while it
// waits, and a finished step holds until rsp_stall drops.
// Synchronous reset clears the load average to zero, sets the bounds to
// 63 and 0 and empties the output register.
`default_nettype none
`include "assert_macros.svh"

module mlfqs_load_priority_unit
   import mlfqs_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [0:0]         csr_index,
   input  wire logic [7:0]         csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_operation,
   input  wire logic [7:0]         req_ready_count,
   input  wire logic               req_cpu_busy,
   input  wire logic signed [31:0] req_recent_cpu_in,
   input  wire logic signed [5:0]  req_nice_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_recent_cpu_out,
   output logic [7:0]              rsp_priority_out,
   output logic signed [31:0]      rsp_load_avg_out,
   output logic signed [31:0]      rsp_load_report
);

   localparam int F         = FRAC_BITS;
   localparam int DW        = 32 + F;
   localparam int CW        = $clog2(DW + 1);
   localparam int MUL_STEPS = 32;
   localparam int MW        = 64 - F;
   localparam int VW        = (F + 11 > 34) ? F + 11 : 34;

   localparam longint unsigned ONE_L = 64'd1 << F;
   localparam logic [31:0] C59    = 32'((59 * ONE_L) / 60);
   localparam logic [31:0] C1     = 32'(ONE_L / 60);
   localparam logic [31:0] C100   = 32'(100 * ONE_L);
   localparam logic [31:0] RND32  = 32'(ONE_L - 1);
   localparam logic [VW-1:0] RNDV = VW'(ONE_L - 1);
   localparam logic signed [32:0] ONE_FX = 33'(ONE_L);

   state_type state_ff, state_in;
   op_type op_ff, op_in;
   logic signed [31:0] recent_ff, recent_in;
   logic signed [5:0] nice_ff, nice_in;
   logic [31:0] bterm_ff, bterm_in;
   logic signed [31:0] dbl_ff, dbl_in;
   logic signed [31:0] den_ff, den_in;
   logic signed [31:0] q_ff, q_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [31:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic dneg_ff, dneg_in;
   logic dzero_ff, dzero_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic signed [31:0] opa_ff, opa_in;
   logic signed [31:0] opb_ff, opb_in;
   logic [31:0] mcand_ff, mcand_in;
   logic [63:0] prod_ff, prod_in;
   logic mneg_ff, mneg_in;
   logic signed [31:0] res_ff, res_in;
   logic signed [VW-1:0] v_ff, v_in;
   logic signed [31:0] load_ff, load_in;
   logic [7:0] max_ff, max_in;
   logic [7:0] min_ff, min_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_rc_ff, rsp_rc_in;
   logic [7:0] rsp_pr_ff, rsp_pr_in;
   logic signed [31:0] rsp_load_ff, rsp_load_in;
   logic signed [31:0] rsp_rep_ff, rsp_rep_in;

   logic req_take;
   logic fin_go;
   logic fin_hold;
   logic load_go;
   logic serial_busy;
   logic signed [31:0] dbl_c, den_c, q_c;
   logic [32:0] div_shift;
   logic [33:0] div_diff;
   logic div_ge;
   logic quo_ovf;
   logic signed [31:0] quo_sig, coef_c;
   logic [32:0] mul_sum;
   logic [MW-1:0] mul_mag;
   logic mul_ovf;
   logic signed [31:0] mul_sig;
   logic signed [VW-1:0] max_x, min_x, q_x, nice_x, v_c, pt_sum, pt_c;
   logic [7:0] pr_c;
   logic signed [32:0] nice33, lsum, rsum;
   logic signed [31:0] upd_load, rc_c, rep_sum, rep_c;

   assign req_take    = req_valid && !req_stall;
   assign req_stall   = (state_ff != ST_IDLE);
   assign fin_go      = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);
   assign fin_hold    = (state_ff == ST_FIN) && !fin_go;
   assign load_go     = fin_go && (op_ff == OP_LOAD);
   assign serial_busy = (state_ff == ST_DIV) || (state_ff == ST_MUL);

   // operand preparation
   assign dbl_c = sat33($signed({load_ff, 1'b0}));
   assign den_c = sat33($signed({dbl_c[31], dbl_c}) + ONE_FX);
   assign q_c   = (recent_ff + (recent_ff[31] ? 32'sd3 : 32'sd0)) >>> 2;

   // restoring divider step
   assign div_shift = {rem_ff, quo_ff[DW-1]};
   assign div_diff  = {1'b0, div_shift} - {2'b00, dvs_ff};
   assign div_ge    = !div_diff[33];

   assign quo_ovf = |quo_ff[DW-1:31];
   assign quo_sig = quo_ovf ? (dneg_ff ? S32_MIN : S32_MAX)
                            : (dneg_ff ? -$signed(quo_ff[31:0]) : $signed(quo_ff[31:0]));

   always_comb begin
      if (dzero_ff) begin
         if (dbl_ff == 32'sd0) begin
            coef_c = 32'sd0;
         end else begin
            coef_c = dbl_ff[31] ? S32_MIN : S32_MAX;
         end
      end else begin
         coef_c = quo_sig;
      end
   end

   // shift-and-add multiplier step
   assign mul_sum = {1'b0, prod_ff[63:32]} + (prod_ff[0] ? {1'b0, mcand_ff} : 33'd0);
   assign mul_mag = prod_ff[63:F];
   assign mul_ovf = |mul_mag[MW-1:31];
   assign mul_sig = mul_ovf ? (mneg_ff ? S32_MIN : S32_MAX)
                            : (mneg_ff ? -$signed(mul_mag[31:0]) : $signed(mul_mag[31:0]));

   // priority
   assign max_x  = $signed({{(VW-8){1'b0}}, max_ff});
   assign min_x  = $signed({{(VW-8){1'b0}}, min_ff});
   assign q_x    = $signed({{(VW-32){q_ff[31]}}, q_ff});
   assign nice_x = $signed({{(VW-6){nice_ff[5]}}, nice_ff});
   assign v_c    = (max_x <<< F) - q_x - (nice_x <<< (F + 1));
   assign pt_sum = v_ff + $signed(v_ff[VW-1] ? RNDV : {VW{1'b0}});
   assign pt_c   = pt_sum >>> F;

   always_comb begin
      priority if (pt_c < min_x) begin
         pr_c = min_ff;
      end else if (pt_c > max_x) begin
         pr_c = max_ff;
      end else begin
         pr_c = pt_c[7:0];
      end
   end

   // final sums
   assign nice33   = $signed({{27{nice_ff[5]}}, nice_ff});
   assign lsum     = $signed({res_ff[31], res_ff}) + $signed({1'b0, bterm_ff});
   assign upd_load = sat33(lsum);
   assign rsum     = $signed({res_ff[31], res_ff}) + (nice33 <<< F);
   assign rc_c     = sat33(rsum);
   assign rep_sum  = res_ff + $signed(res_ff[31] ? RND32 : 32'd0);
   assign rep_c    = rep_sum >>> F;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      recent_in    = recent_ff;
      nice_in      = nice_ff;
      bterm_in     = bterm_ff;
      dbl_in       = dbl_ff;
      den_in       = den_ff;
      q_in         = q_ff;
      dvs_in       = dvs_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dneg_in      = dneg_ff;
      dzero_in     = dzero_ff;
      cnt_in       = cnt_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      mcand_in     = mcand_ff;
      prod_in      = prod_ff;
      mneg_in      = mneg_ff;
      res_in       = res_ff;
      v_in         = v_ff;
      load_in      = load_ff;
      max_in       = max_ff;
      min_in       = min_ff;
      rsp_rc_in    = rsp_rc_ff;
      rsp_pr_in    = rsp_pr_ff;
      rsp_load_in  = rsp_load_ff;
      rsp_rep_in   = rsp_rep_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAX_PRIORITY: max_in = csr_wdata;
            CSR_MIN_PRIORITY: min_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               op_in     = op_type'(req_operation);
               recent_in = req_recent_cpu_in;
               nice_in   = req_nice_value;
               bterm_in  = 32'(({1'b0, req_ready_count} + 9'(req_cpu_busy)) * C1);
               state_in  = ST_PREP;
            end
         end
         ST_PREP: begin
            unique case (op_ff)
               OP_LOAD: begin
                  opa_in   = $signed(C59);
                  opb_in   = load_ff;
                  state_in = ST_MLOAD;
               end
               OP_RECENT: begin
                  dbl_in   = dbl_c;
                  den_in   = den_c;
                  state_in = ST_DLOAD;
               end
               OP_PRIORITY: begin
                  q_in     = q_c;
                  state_in = ST_PRI;
               end
               OP_REPORT: begin
                  opa_in   = $signed(C100);
                  opb_in   = load_ff;
                  state_in = ST_MLOAD;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_DLOAD: begin
            dvs_in   = mag32(den_ff);
            quo_in   = {mag32(dbl_ff), {F{1'b0}}};
            rem_in   = 32'd0;
            dneg_in  = dbl_ff[31] ^ den_ff[31];
            dzero_in = (den_ff == 32'sd0);
            cnt_in   = CW'(DW);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = div_ge ? div_diff[31:0] : div_shift[31:0];
            quo_in = {quo_ff[DW-2:0], div_ge};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = ST_CSET;
            end
         end
         ST_CSET: begin
            opa_in   = coef_c;
            opb_in   = recent_ff;
            state_in = ST_MLOAD;
         end
         ST_MLOAD: begin
            mcand_in = mag32(opa_ff);
            prod_in  = {32'd0, mag32(opb_ff)};
            mneg_in  = opa_ff[31] ^ opb_ff[31];
            cnt_in   = CW'(MUL_STEPS);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in = {mul_sum, prod_ff[31:1]};
            cnt_in  = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = ST_MSAT;
            end
         end
         ST_MSAT: begin
            res_in   = mul_sig;
            state_in = ST_FIN;
         end
         ST_PRI: begin
            v_in     = v_c;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (fin_go) begin
               rsp_valid_in = 1'b1;
               rsp_rc_in    = 32'sd0;
               rsp_pr_in    = 8'd0;
               rsp_rep_in   = 32'sd0;
               rsp_load_in  = load_ff;
               unique case (op_ff)
                  OP_LOAD: begin
                     load_in     = upd_load;
                     rsp_load_in = upd_load;
                  end
                  OP_RECENT:   rsp_rc_in  = rc_c;
                  OP_PRIORITY: rsp_pr_in  = pr_c;
                  OP_REPORT:   rsp_rep_in = rep_c;
                  default: ;
               endcase
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         load_ff      <= 32'sd0;
         max_ff       <= MAX_PRIORITY_RESET;
         min_ff       <= MIN_PRIORITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_ff      <= load_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      recent_ff   <= recent_in;
      nice_ff     <= nice_in;
      bterm_ff    <= bterm_in;
      dbl_ff      <= dbl_in;
      den_ff      <= den_in;
      q_ff        <= q_in;
      dvs_ff      <= dvs_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dneg_ff     <= dneg_in;
      dzero_ff    <= dzero_in;
      cnt_ff      <= cnt_in;
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      mcand_ff    <= mcand_in;
      prod_ff     <= prod_in;
      mneg_ff     <= mneg_in;
      res_ff      <= res_in;
      v_ff        <= v_in;
      rsp_rc_ff   <= rsp_rc_in;
      rsp_pr_ff   <= rsp_pr_in;
      rsp_load_ff <= rsp_load_in;
      rsp_rep_ff  <= rsp_rep_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_recent_cpu_out = rsp_rc_ff;
   assign rsp_priority_out   = rsp_pr_ff;
   assign rsp_load_avg_out   = rsp_load_ff;
   assign rsp_load_report    = rsp_rep_ff;

   `ASSERT_NEXT(a_accept_starts, clock, reset, req_take, state_ff == ST_PREP, "step not started")
   `ASSERT_NEXT(a_fin_waits, clock, reset, fin_hold, state_ff == ST_FIN, "step left early")
   `ASSERT_NEXT(a_load_hold, clock, reset, !load_go, $stable(load_ff), "load changed")
   `ASSERT_ALWAYS(a_counter_live, clock, reset, !serial_busy || cnt_ff != '0, "counter ran out")

endmodule

`default_nettype wire
